@@ sv/spbm_pkg.sv @@
// ----------------------------------------------------------------------------
// Spectrum band mask package
// Shared constants, register codes, configuration and chain record types,
// and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package spbm_pkg;

  localparam int MAX_BINS      = 4096;
  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_STEPS    = 32;
  localparam int CELLS         = SQRT_STEPS;
  localparam int CELL_IDX_W    = $clog2(CELLS);

  localparam int COUNT_W     = 13;
  localparam int INDEX_W     = 12;
  localparam int DATA_W      = 32;
  localparam int PHASE_W     = 16;
  localparam int CORDIC_W    = 36;
  localparam int ROOT_W      = 64;
  localparam int REG_INDEX_W = 3;

  localparam logic [DATA_W-1:0] ANGLE_PI   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ROUND_HALF = 32'h0000_8000;
  localparam logic [DATA_W-1:0] REAL_MAX   = 32'h7FFF_FFFF;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_BIN_COUNT           = 3'd0,
    REG_KEEP_FROM           = 3'd1,
    REG_KEEP_TO             = 3'd2,
    REG_ERASE_PHASE         = 3'd3,
    REG_AMPLITUDE_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] keep_from;
    logic [COUNT_W-1:0] keep_to;
    logic               erase_phase;
    logic [DATA_W-1:0]  amplitude_threshold;
  } cfg_t;

  typedef struct packed {
    logic                       valid;
    logic                       keep;
    logic                       erase;
    logic                       phase_zero;
    logic signed [DATA_W-1:0]   re;
    logic signed [DATA_W-1:0]   im;
    logic [ROOT_W-1:0]          rem;
    logic [ROOT_W-1:0]          root;
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic [DATA_W-1:0]          acc;
  } chain_t;

  function automatic logic [DATA_W-1:0] atan_angle(input logic [CELL_IDX_W-1:0] idx);
    logic [DATA_W-1:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ sv/spbm_if.sv @@
// ----------------------------------------------------------------------------
// Spectrum band mask channels
// Valid/ready channels for incoming bins and for masked polar results.
// ----------------------------------------------------------------------------
interface spbm_in_if;
  import spbm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [INDEX_W-1:0]       bin_index;
  logic signed [DATA_W-1:0] real_part;
  logic signed [DATA_W-1:0] imag_part;

  modport source (output valid, bin_index, real_part, imag_part, input ready);
  modport sink (input valid, bin_index, real_part, imag_part, output ready);
endinterface

interface spbm_out_if;
  import spbm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  kept_real;
  logic signed [DATA_W-1:0]  kept_imag;
  logic [DATA_W-1:0]         amplitude;
  logic signed [PHASE_W-1:0] phase;

  modport source (output valid, kept_real, kept_imag, amplitude, phase, input ready);
  modport sink (input valid, kept_real, kept_imag, amplitude, phase, output ready);
endinterface

@@ sv/spbm_front.sv @@
// ----------------------------------------------------------------------------
// Spectrum band mask front end
// Band decision, CORDIC pre-rotation, squaring and sum of squares ahead of
// the cell chain.
// ----------------------------------------------------------------------------
module spbm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  spbm_pkg::cfg_t  cfg,
  spbm_in_if.sink         spectrum,
  output spbm_pkg::chain_t head
);
  import spbm_pkg::*;

  logic [COUNT_W-1:0] n, lo, hi, mir_lo, mir_hi, k;
  logic               keep;
  logic [DATA_W-1:0]  ar, ai;
  chain_t             entry;

  chain_t             st_a;
  logic [DATA_W-1:0]  ar_a, ai_a;
  chain_t             st_b;
  logic [ROOT_W-1:0]  sq_r, sq_i;
  chain_t             head_next;

  assign spectrum.ready = advance && !rst;

  always_comb begin
    n      = (cfg.bin_count > COUNT_W'(MAX_BINS)) ? COUNT_W'(MAX_BINS) : cfg.bin_count;
    lo     = (cfg.keep_from > n) ? n : cfg.keep_from;
    hi     = (cfg.keep_to > n) ? n : cfg.keep_to;
    mir_lo = n - hi;
    mir_hi = n - lo;
    k      = COUNT_W'(spectrum.bin_index);
    keep   = (lo <= k && k <= hi) || (mir_lo <= k && k <= mir_hi);
    ar     = spectrum.real_part[DATA_W-1] ? (~spectrum.real_part + 1'b1) : spectrum.real_part;
    ai     = spectrum.imag_part[DATA_W-1] ? (~spectrum.imag_part + 1'b1) : spectrum.imag_part;

    entry            = '0;
    entry.valid      = spectrum.valid;
    entry.keep       = keep;
    entry.erase      = cfg.erase_phase;
    entry.phase_zero = cfg.erase_phase ||
                       (spectrum.real_part == '0 && spectrum.imag_part == '0);
    entry.re         = spectrum.real_part;
    entry.im         = spectrum.imag_part;
    if (spectrum.real_part[DATA_W-1]) begin
      entry.cx  = -CORDIC_W'(spectrum.real_part);
      entry.cy  = -CORDIC_W'(spectrum.imag_part);
      entry.acc = ANGLE_PI;
    end else begin
      entry.cx  = CORDIC_W'(spectrum.real_part);
      entry.cy  = CORDIC_W'(spectrum.imag_part);
      entry.acc = '0;
    end
  end

  always_comb begin
    head_next      = st_b;
    head_next.rem  = sq_r + sq_i;
    head_next.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_a.valid <= 1'b0;
      st_b.valid <= 1'b0;
      head.valid <= 1'b0;
    end else if (advance) begin
      st_a <= entry;
      ar_a <= ar;
      ai_a <= ai;
      st_b <= st_a;
      sq_r <= ROOT_W'(ar_a) * ROOT_W'(ar_a);
      sq_i <= ROOT_W'(ai_a) * ROOT_W'(ai_a);
      head <= head_next;
    end
  end

endmodule

@@ sv/spbm_cell.sv @@
// ----------------------------------------------------------------------------
// Spectrum band mask chain cell
// One step of the digit-by-digit square root and, in the first stages, one
// CORDIC vectoring rotation; hands its record to the next cell.
// ----------------------------------------------------------------------------
module spbm_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic [spbm_pkg::CELL_IDX_W-1:0]  stage,
  input  spbm_pkg::chain_t                 prev,
  output spbm_pkg::chain_t                 next
);
  import spbm_pkg::*;

  localparam int SH_W = CELL_IDX_W + 1;

  logic [SH_W-1:0]            sh;
  logic [ROOT_W-1:0]          digit, trial;
  logic                       rot_on;
  logic signed [CORDIC_W-1:0] xs, ys;
  logic [DATA_W-1:0]          angle;
  chain_t                     step;

  always_comb begin
    sh     = SH_W'(2 * (SQRT_STEPS - 1)) - {stage, 1'b0};
    digit  = ROOT_W'(1) << sh;
    trial  = prev.root | digit;
    rot_on = {1'b0, stage} < SH_W'(CORDIC_STAGES);
    xs     = prev.cx >>> stage;
    ys     = prev.cy >>> stage;
    angle  = atan_angle(stage);

    step = prev;
    if (prev.rem >= trial) begin
      step.rem  = prev.rem - trial;
      step.root = (prev.root >> 1) | digit;
    end else begin
      step.root = prev.root >> 1;
    end
    if (rot_on) begin
      if (!prev.cy[CORDIC_W-1]) begin
        step.cx  = prev.cx + ys;
        step.cy  = prev.cy - xs;
        step.acc = prev.acc + angle;
      end else begin
        step.cx  = prev.cx - ys;
        step.cy  = prev.cy + xs;
        step.acc = prev.acc - angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (advance) begin
      next <= step;
    end
  end

endmodule

@@ sv/spbm_back.sv @@
// ----------------------------------------------------------------------------
// Spectrum band mask back end
// Masking of outputs, saturation, threshold test, phase rounding and the
// output register that holds a result until taken.
// ----------------------------------------------------------------------------
module spbm_back (
  input  logic             clk,
  input  logic             rst,
  input  spbm_pkg::cfg_t   cfg,
  input  spbm_pkg::chain_t tail,
  output logic             advance,
  spbm_out_if.source       polar
);
  import spbm_pkg::*;

  logic [DATA_W-1:0]         mag, amp, rounded;
  logic signed [DATA_W-1:0]  kr, ki;
  logic signed [PHASE_W-1:0] ph;

  assign advance = !polar.valid || polar.ready;

  always_comb begin
    mag     = tail.root[DATA_W-1:0];
    rounded = tail.acc + ROUND_HALF;
    kr      = '0;
    ki      = '0;
    amp     = '0;
    ph      = '0;
    if (tail.keep) begin
      amp = mag;
      if (tail.erase) begin
        kr = mag[DATA_W-1] ? REAL_MAX : mag;
      end else begin
        kr = tail.re;
        ki = tail.im;
      end
      if (!tail.phase_zero) begin
        ph = rounded[DATA_W-1 -: PHASE_W];
      end
    end
    if (amp < cfg.amplitude_threshold) begin
      amp = '0;
      ph  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polar.valid <= 1'b0;
    end else if (advance) begin
      polar.valid     <= tail.valid;
      polar.kept_real <= kr;
      polar.kept_imag <= ki;
      polar.amplitude <= amp;
      polar.phase     <= ph;
    end
  end

endmodule

@@ sv/spectrum_band_mask_polar.sv @@
// ----------------------------------------------------------------------------
// Spectrum band mask with polar read-out
// Masks FFT bins to a band and its mirror and reports amplitude and phase.
// ----------------------------------------------------------------------------
// Takes one bin per cycle while the result side does not stall and gives
// one result per bin, in order. The chain of 32 cells, each resolving one
// bit of the exact square root of re^2 + im^2 (the first 16 also run one
// CORDIC rotation for the phase), sits behind three entry stages (band
// decision, squaring, sum) and ahead of the output register. A stall on
// the result side holds the whole chain.
// ----------------------------------------------------------------------------
module spectrum_band_mask_polar (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [spbm_pkg::REG_INDEX_W-1:0] reg_index,
  input  logic [spbm_pkg::DATA_W-1:0]      write_data,
  spbm_in_if.sink                          spectrum,
  spbm_out_if.source                       polar
);
  import spbm_pkg::*;

  cfg_t   cfg;
  logic   advance;
  chain_t chain [CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bin_count           <= COUNT_W'(4096);
      cfg.keep_from           <= '0;
      cfg.keep_to             <= COUNT_W'(4096);
      cfg.erase_phase         <= 1'b0;
      cfg.amplitude_threshold <= DATA_W'(33);
    end else if (write_enable) begin
      case (cfg_reg_t'(reg_index))
        REG_BIN_COUNT:           cfg.bin_count           <= write_data[COUNT_W-1:0];
        REG_KEEP_FROM:           cfg.keep_from           <= write_data[COUNT_W-1:0];
        REG_KEEP_TO:             cfg.keep_to             <= write_data[COUNT_W-1:0];
        REG_ERASE_PHASE:         cfg.erase_phase         <= write_data[0];
        REG_AMPLITUDE_THRESHOLD: cfg.amplitude_threshold <= write_data;
        default: ;
      endcase
    end
  end

  spbm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cfg      (cfg),
    .spectrum (spectrum),
    .head     (chain[0])
  );

  for (genvar g = 0; g < CELLS; g++) begin : g_chain
    spbm_cell u_stage (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .stage   (CELL_IDX_W'(g)),
      .prev    (chain[g]),
      .next    (chain[g+1])
    );
  end

  spbm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .tail    (chain[CELLS]),
    .advance (advance),
    .polar   (polar)
  );

endmodule

@@ sim/spbm_checker.sv @@
// ----------------------------------------------------------------------------
// Spectrum band mask checker
// Watches the bin and polar channels and the register write port, predicts
// the masked bin, amplitude and phase of every accepted request, and compares
// each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spbm_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [spbm_pkg::REG_INDEX_W-1:0] reg_index,
  input  logic [spbm_pkg::DATA_W-1:0]      write_data,
  spbm_in_if                               spectrum,
  spbm_out_if                              polar,
  output int                               mismatches,
  output int                               pending
);
  import spbm_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0]  kept_real;
    logic signed [DATA_W-1:0]  kept_imag;
    logic [DATA_W-1:0]         amplitude;
    logic signed [PHASE_W-1:0] phase;
  } polar_t;

  localparam logic [COUNT_W-1:0] BIN_COUNT_RST = 13'd4096;
  localparam logic [COUNT_W-1:0] KEEP_FROM_RST = 13'd0;
  localparam logic [COUNT_W-1:0] KEEP_TO_RST   = 13'd4096;
  localparam logic [DATA_W-1:0]  THRESH_RST    = 32'd33;

  localparam logic [DATA_W-1:0] ARCTAN_STEP [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  cfg_t   mask_cfg;
  polar_t polar_q[$];
  int     err_total;

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] rest;
    logic [63:0] res;
    logic [63:0] probe;
    rest  = v;
    res   = '0;
    probe = 64'h1 << 62;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= res + probe) begin
        rest = rest - (res + probe);
        res  = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic logic [PHASE_W-1:0] vector_angle(input logic signed [63:0] x,
                                                      input logic signed [63:0] y);
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic [DATA_W-1:0]  acc;
    logic [DATA_W-1:0]  rounded;
    if (x == 0 && y == 0) return '0;
    cx  = x;
    cy  = y;
    acc = '0;
    if (cx < 0) begin
      cx  = -cx;
      cy  = -cy;
      acc = ANGLE_PI;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx  = cx + ys;
        cy  = cy - xs;
        acc = acc + ARCTAN_STEP[i];
      end else begin
        cx  = cx - ys;
        cy  = cy + xs;
        acc = acc - ARCTAN_STEP[i];
      end
    end
    rounded = acc + ROUND_HALF;
    return rounded[DATA_W-1:16];
  endfunction

  function automatic polar_t masked_polar(input cfg_t c, input logic [INDEX_W-1:0] k,
                                          input logic signed [DATA_W-1:0] re,
                                          input logic signed [DATA_W-1:0] im);
    int                 n;
    int                 lo;
    int                 hi;
    int                 kk;
    logic               keep;
    logic signed [63:0] re64;
    logic signed [63:0] im64;
    logic [63:0]        ar;
    logic [63:0]        ai;
    logic [63:0]        mag;
    logic [63:0]        amp;
    polar_t             r;
    n    = (c.bin_count > MAX_BINS) ? MAX_BINS : int'(c.bin_count);
    lo   = (int'(c.keep_from) > n) ? n : int'(c.keep_from);
    hi   = (int'(c.keep_to) > n) ? n : int'(c.keep_to);
    kk   = int'(k);
    keep = (lo <= kk && kk <= hi) || (n - hi <= kk && kk <= n - lo);
    re64 = re;
    im64 = im;
    ar   = (re64 < 0) ? -re64 : re64;
    ai   = (im64 < 0) ? -im64 : im64;
    mag  = floor_root(ar * ar + ai * ai);
    r    = '0;
    amp  = '0;
    if (keep) begin
      amp = mag;
      if (c.erase_phase) begin
        r.kept_real = (mag > REAL_MAX) ? REAL_MAX : mag[DATA_W-1:0];
      end else begin
        r.kept_real = re;
        r.kept_imag = im;
        r.phase     = vector_angle(re64, im64);
      end
    end
    if (amp < c.amplitude_threshold) begin
      amp     = '0;
      r.phase = '0;
    end
    r.amplitude = amp[DATA_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    polar_t want;
    if (rst) begin
      mask_cfg.bin_count           = BIN_COUNT_RST;
      mask_cfg.keep_from           = KEEP_FROM_RST;
      mask_cfg.keep_to             = KEEP_TO_RST;
      mask_cfg.erase_phase         = 1'b0;
      mask_cfg.amplitude_threshold = THRESH_RST;
      polar_q.delete();
    end else begin
      if (write_enable) begin
        case (reg_index)
          REG_BIN_COUNT:           mask_cfg.bin_count = write_data[COUNT_W-1:0];
          REG_KEEP_FROM:           mask_cfg.keep_from = write_data[COUNT_W-1:0];
          REG_KEEP_TO:             mask_cfg.keep_to = write_data[COUNT_W-1:0];
          REG_ERASE_PHASE:         mask_cfg.erase_phase = write_data[0];
          REG_AMPLITUDE_THRESHOLD: mask_cfg.amplitude_threshold = write_data;
          default: ;
        endcase
      end
      if (spectrum.valid && spectrum.ready)
        polar_q.push_back(masked_polar(mask_cfg, spectrum.bin_index,
                                       spectrum.real_part, spectrum.imag_part));
      if (polar.valid && polar.ready) begin
        if (polar_q.size() == 0) begin
          err_total++;
          $display("%0t: unexpected result, got re %0d im %0d amp %0d ph %0d", $time,
                   polar.kept_real, polar.kept_imag, polar.amplitude, polar.phase);
        end else begin
          want = polar_q.pop_front();
          if (polar.kept_real !== want.kept_real) begin
            err_total++;
            $display("%0t: kept_real expected %0d, got %0d", $time,
                     want.kept_real, polar.kept_real);
          end
          if (polar.kept_imag !== want.kept_imag) begin
            err_total++;
            $display("%0t: kept_imag expected %0d, got %0d", $time,
                     want.kept_imag, polar.kept_imag);
          end
          if (polar.amplitude !== want.amplitude) begin
            err_total++;
            $display("%0t: amplitude expected %0d, got %0d", $time,
                     want.amplitude, polar.amplitude);
          end
          if (polar.phase !== want.phase) begin
            err_total++;
            $display("%0t: phase expected %0d, got %0d", $time, want.phase, polar.phase);
          end
        end
      end
    end
    mismatches <= err_total;
    pending    <= polar_q.size();
  end

endmodule

@@ sim/tb_spectrum_band_mask_polar.sv @@
// ----------------------------------------------------------------------------
// Spectrum band mask testbench
// Drives directed and random FFT bins through the band mask under a range of
// band, mirror, phase-erase and threshold settings, with random gaps on the
// bin side and random stalls on the result side; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_spectrum_band_mask_polar;
  import spbm_pkg::*;

  localparam int LATENCY = 36;
  localparam int ITEMS_PER_SET = 106;

  logic                   clk;
  logic                   rst;
  logic                   write_enable;
  logic [REG_INDEX_W-1:0] reg_index;
  logic [DATA_W-1:0]      write_data;
  int                     mismatches;
  int                     pending;
  int                     send_idle_pct;
  int                     stall_pct;
  logic [COUNT_W-1:0]     set_count;
  logic [COUNT_W-1:0]     set_from;
  logic [COUNT_W-1:0]     set_to;

  spbm_in_if  spectrum_ch ();
  spbm_out_if polar_ch ();

  spectrum_band_mask_polar u_top (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .spectrum     (spectrum_ch),
    .polar        (polar_ch)
  );

  spbm_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .spectrum     (spectrum_ch),
    .polar        (polar_ch),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    polar_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic wait_drained();
    spectrum_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= val;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic apply_setting(input logic [COUNT_W-1:0] count, input logic [COUNT_W-1:0] from,
                               input logic [COUNT_W-1:0] upto, input logic erase,
                               input logic [DATA_W-1:0] thresh);
    wait_drained();
    write_reg(REG_BIN_COUNT, DATA_W'(count));
    write_reg(REG_KEEP_FROM, DATA_W'(from));
    write_reg(REG_KEEP_TO, DATA_W'(upto));
    write_reg(REG_ERASE_PHASE, DATA_W'(erase));
    write_reg(REG_AMPLITUDE_THRESHOLD, thresh);
    set_count = count;
    set_from  = from;
    set_to    = upto;
  endtask

  task automatic send_bin(input logic [INDEX_W-1:0] k, input logic signed [DATA_W-1:0] re,
                          input logic signed [DATA_W-1:0] im);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      spectrum_ch.valid <= 1'b0;
      @(posedge clk);
    end
    spectrum_ch.valid     <= 1'b1;
    spectrum_ch.bin_index <= k;
    spectrum_ch.real_part <= re;
    spectrum_ch.imag_part <= im;
    @(posedge clk);
    while (!spectrum_ch.ready) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        v = $urandom_range(0, 80);
        if ($urandom_range(0, 1)) v = -v;
      end
      1: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      2: v = $urandom_range(0, 32'h0001_FFFF) - 32'sh0001_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic choose_setting(input int sel);
    logic [DATA_W-1:0] thresh;
    case (sel)
      0: apply_setting(13'd4096, 13'd0, 13'd4096, 1'b0, 32'd0);
      1: apply_setting(13'd64, 13'd5, 13'd20, 1'b0, 32'd33);
      2: apply_setting(13'd8191, 13'd100, 13'd5000, 1'b1, 32'd33);
      3: apply_setting(13'd0, 13'd0, 13'd0, 1'b0, 32'd33);
      4: apply_setting(13'd1, 13'd0, 13'd1, 1'b1, 32'd0);
      5: apply_setting(13'd4096, 13'd300, 13'd200, 1'b0, 32'd33);
      6: apply_setting(13'd4096, 13'd8191, 13'd8191, 1'b1, 32'hFFFF_FFFF);
      default: begin
        case ($urandom_range(0, 4))
          0: thresh = 32'd0;
          1: thresh = 32'd33;
          2: thresh = $urandom_range(0, 32'h0002_0000);
          3: thresh = 32'hFFFF_FFFF;
          default: thresh = $urandom;
        endcase
        if ($urandom_range(0, 2) == 0)
          apply_setting(COUNT_W'($urandom_range(0, 8191)), COUNT_W'($urandom_range(0, 8191)),
                        COUNT_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)), thresh);
        else
          apply_setting(COUNT_W'($urandom_range(2, 4096)), COUNT_W'($urandom_range(0, 600)),
                        COUNT_W'($urandom_range(0, 2100)), 1'($urandom_range(0, 1)), thresh);
      end
    endcase
  endtask

  initial begin
    int                 base;
    int                 n_eff;
    logic [INDEX_W-1:0] k;
    rst                   = 1'b1;
    write_enable          = 1'b0;
    reg_index             = '0;
    write_data            = '0;
    spectrum_ch.valid     = 1'b0;
    spectrum_ch.bin_index = '0;
    spectrum_ch.real_part = '0;
    spectrum_ch.imag_part = '0;
    send_idle_pct         = 0;
    stall_pct             = 0;
    set_count             = 13'd4096;
    set_from              = 13'd0;
    set_to                = 13'd4096;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_bin(12'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_bin(12'd4095, 32'sh8000_0000, 32'sh8000_0000);
    send_bin(12'd1, 32'sh8000_0000, 32'sh0);
    send_bin(12'd2, 32'sh0, 32'sh8000_0000);
    send_bin(12'd3, 32'sh0, 32'sh0);
    send_bin(12'd4, -32'sh0001_0000, 32'sh0);
    send_bin(12'd5, -32'sh1, 32'sh0);
    send_bin(12'd6, 32'sh0, 32'sh0001_0000);
    send_bin(12'd7, 32'sh10, 32'sh10);
    send_bin(12'd8, 32'sh21, 32'sh0);
    send_bin(12'd9, 32'sh20, 32'sh0);
    send_bin(12'd10, -32'sh0003_0000, -32'sh0004_0000);
    send_bin(12'd2048, 32'sh0003_0000, -32'sh0004_0000);
    send_bin(12'd11, -32'sh0002_0000, 32'sh1);

    apply_setting(13'd4096, 13'd0, 13'd4096, 1'b1, 32'd33);
    send_bin(12'd0, 32'sh8000_0000, 32'sh8000_0000);
    send_bin(12'd100, 32'sh0003_0000, -32'sh0004_0000);
    send_bin(12'd200, -32'sh7FFF_FFFF, 32'sh0);

    apply_setting(13'd64, 13'd5, 13'd20, 1'b0, 32'd0);
    send_bin(12'd4, 32'sh0001_0000, 32'sh0001_0000);
    send_bin(12'd5, 32'sh0001_0000, 32'sh0001_0000);
    send_bin(12'd20, 32'sh0001_0000, 32'sh0001_0000);
    send_bin(12'd21, 32'sh0001_0000, 32'sh0001_0000);
    send_bin(12'd44, 32'sh0001_0000, 32'sh0001_0000);
    send_bin(12'd59, 32'sh0001_0000, 32'sh0001_0000);
    send_bin(12'd60, 32'sh0001_0000, 32'sh0001_0000);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      for (int s = 0; s < 4; s++) begin
        choose_setting(ph * 4 + s);
        n_eff = (set_count > MAX_BINS) ? MAX_BINS : int'(set_count);
        for (int j = 0; j < ITEMS_PER_SET; j++) begin
          if ($urandom_range(0, 1)) begin
            k = INDEX_W'($urandom);
          end else begin
            case ($urandom_range(0, 3))
              0: base = int'(set_from);
              1: base = int'(set_to);
              2: base = n_eff - int'(set_to);
              default: base = n_eff - int'(set_from);
            endcase
            k = INDEX_W'(base + int'($urandom_range(0, 2)) - 1);
          end
          send_bin(k, pick_value(), pick_value());
          if (j == ITEMS_PER_SET / 2 && s == 1) wait_drained();
        end
      end
    end

    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_spectrum_band_mask_polar: PASS");
    end else begin
      $display("tb_spectrum_band_mask_polar: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_spectrum_band_mask_polar: FAIL");
    $finish;
  end

endmodule
